// ===== hw/rtl/trm_pkg.sv =====
// Shared types and constants for the register machine execute unit.
// Used by the front decode, the instruction queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trm_pkg;

    // Machine shape
    localparam int DATA_WIDTH    = 32;
    localparam int NUM_REGISTERS = 5;
    localparam int RF_AW         = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam logic [RF_AW-1:0] RESULT_REG = RF_AW'(NUM_REGISTERS - 1);

    // Fixed field widths of the instruction and result
    localparam int CMD_W     = 4;
    localparam int REG_IDX_W = 3;
    localparam int LIT_W     = 31;
    localparam int PRINT_W   = 32;
    localparam int CHAR_W    = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(DATA_WIDTH);

    // Instruction codes as they arrive
    typedef enum logic [CMD_W-1:0] {
        CMD_NOP       = 4'd0,
        CMD_MOV       = 4'd1,
        CMD_ADD       = 4'd2,
        CMD_SUB       = 4'd3,
        CMD_MUL       = 4'd4,
        CMD_DIV       = 4'd5,
        CMD_CMP       = 4'd6,
        CMD_JMP       = 4'd7,
        CMD_JE        = 4'd8,
        CMD_JNE       = 4'd9,
        CMD_JG        = 4'd10,
        CMD_JL        = 4'd11,
        CMD_JGE       = 4'd12,
        CMD_JLE       = 4'd13,
        CMD_PRINTINT  = 4'd14,
        CMD_PRINTCHAR = 4'd15
    } t_cmd;

    // Operation class after decode
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CMP,
        OP_JUMP,
        OP_PRINT
    } t_op;

    // Jump condition
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_EQ,
        COND_NE,
        COND_GT,
        COND_LT,
        COND_GE,
        COND_LE
    } t_cond;

    // Decoded instruction carried through the queue
    typedef struct packed {
        t_op                  op;
        t_cond                cond;
        logic                 is_char;
        logic                 wr_left;
        logic                 left_is_literal;
        logic [REG_IDX_W-1:0] left_reg;
        logic [LIT_W-1:0]     left_literal;
        logic                 right_is_literal;
        logic [REG_IDX_W-1:0] right_reg;
        logic [LIT_W-1:0]     right_literal;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic                      branch_taken;
        logic                      print_valid;
        logic                      print_is_char;
        logic signed [PRINT_W-1:0] print_value;
        logic                      divide_error;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/trm_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                          i_wdata,
    input  wire                                       i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                          o_rdata_a,
    output logic [WIDTH-1:0]                          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trm_front.sv =====
// Front end: accepts instruction transactions and classifies the command.
// Depends on trm_pkg; feeds trm_queue.
`timescale 1ns / 1ps
`default_nettype none

module trm_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [trm_pkg::CMD_W-1:0]       i_command,
    input  wire                             i_left_is_literal,
    input  wire  [trm_pkg::REG_IDX_W-1:0]   i_left_reg,
    input  wire  [trm_pkg::LIT_W-1:0]       i_left_literal,
    input  wire                             i_right_is_literal,
    input  wire  [trm_pkg::REG_IDX_W-1:0]   i_right_reg,
    input  wire  [trm_pkg::LIT_W-1:0]       i_right_literal,
    output logic                            o_push,
    output trm_pkg::t_item                  o_item,
    input  wire                             i_queue_ready
);
    import trm_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Classify the command
    always_comb begin
        n_item                  = '0;
        n_item.op               = OP_NOP;
        n_item.cond             = COND_ALWAYS;
        n_item.left_is_literal  = i_left_is_literal;
        n_item.left_reg         = i_left_reg;
        n_item.left_literal     = i_left_literal;
        n_item.right_is_literal = i_right_is_literal;
        n_item.right_reg        = i_right_reg;
        n_item.right_literal    = i_right_literal;
        unique case (t_cmd'(i_command))
            CMD_NOP:       n_item.op = OP_NOP;
            CMD_MOV:       n_item.op = OP_MOV;
            CMD_ADD:       n_item.op = OP_ADD;
            CMD_SUB:       n_item.op = OP_SUB;
            CMD_MUL:       n_item.op = OP_MUL;
            CMD_DIV:       n_item.op = OP_DIV;
            CMD_CMP:       n_item.op = OP_CMP;
            CMD_JMP: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_ALWAYS;
            end
            CMD_JE: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_EQ;
            end
            CMD_JNE: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_NE;
            end
            CMD_JG: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_GT;
            end
            CMD_JL: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_LT;
            end
            CMD_JGE: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_GE;
            end
            CMD_JLE: begin
                n_item.op   = OP_JUMP;
                n_item.cond = COND_LE;
            end
            CMD_PRINTINT:  n_item.op = OP_PRINT;
            CMD_PRINTCHAR: begin
                n_item.op      = OP_PRINT;
                n_item.is_char = 1'b1;
            end
        endcase
        // A literal destination leaves the register file alone
        n_item.wr_left = ((n_item.op == OP_MOV) || (n_item.op == OP_ADD) ||
                          (n_item.op == OP_SUB)) && !i_left_is_literal;
    end

    assign o_ready = !r_valid || i_queue_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    // Hold one classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_item  <= n_item;
            end else if (i_queue_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trm_queue.sv =====
// Short instruction queue between the front end and the back end.
// Depends on trm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trm_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  trm_pkg::t_item      i_item,
    output logic                o_in_ready,
    input  wire                 i_pop,
    output logic                o_out_valid,
    output trm_pkg::t_item      o_item
);
    import trm_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];
    assign push_ok     = i_push && o_in_ready;
    assign pop_ok      = i_pop && o_out_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trm_back.sv =====
// Back end: reads operands, executes, runs the iterative divider and holds the result.
// Depends on trm_pkg and trm_ram (register file).
`timescale 1ns / 1ps
`default_nettype none

module trm_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  trm_pkg::t_item      i_q_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output trm_pkg::t_result    o_result
);
    import trm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIX
    } t_state;

    localparam int W = DATA_WIDTH;

    t_state                 r_state;
    t_item                  r_item;
    logic [NUM_REGISTERS-1:0] r_rf_vld;
    logic                   r_a_ok;
    logic                   r_b_ok;
    logic                   r_left_in;
    logic                   r_zf;
    logic                   r_cf;
    logic                   r_out_valid;
    t_result                r_out;
    logic [W-1:0]           r_rem;
    logic [W-1:0]           r_quo;
    logic [W-1:0]           r_divisor;
    logic                   r_neg;
    logic [DIV_CNT_W-1:0]   r_cnt;

    logic [W-1:0]           rd_a;
    logic [W-1:0]           rd_b;
    logic [W-1:0]           a_val;
    logic [W-1:0]           b_val;
    logic [W-1:0]           sum;
    logic [W-1:0]           diff;
    logic [W-1:0]           prod;
    logic [W-1:0]           mag_a;
    logic [W-1:0]           mag_b;
    logic [W:0]             rem_sh;
    logic [W:0]             rem_try;
    logic                   quo_bit;
    logic [W-1:0]           quo_fixed;
    logic                   taken;
    logic                   rf_we;
    logic [RF_AW-1:0]       rf_waddr;
    logic [W-1:0]           rf_wdata;
    logic                   load_out;
    t_result                n_out;
    logic                   q_left_in;
    logic                   q_right_in;

    // Take the next transaction only when the result register will be free
    assign o_pop = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || i_ready);

    assign q_left_in  = (int'(i_q_item.left_reg) < NUM_REGISTERS);
    assign q_right_in = (int'(i_q_item.right_reg) < NUM_REGISTERS);

    trm_ram #(
        .WIDTH (W),
        .DEPTH (NUM_REGISTERS)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (rf_we),
        .i_waddr   (rf_waddr),
        .i_wdata   (rf_wdata),
        .i_re      (o_pop),
        .i_raddr_a (RF_AW'(i_q_item.left_reg)),
        .i_raddr_b (RF_AW'(i_q_item.right_reg)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Operands: literal, register, or zero for unwritten or missing registers
    always_comb begin
        a_val = r_item.left_is_literal  ? W'(r_item.left_literal)  : (r_a_ok ? rd_a : '0);
        b_val = r_item.right_is_literal ? W'(r_item.right_literal) : (r_b_ok ? rd_b : '0);
        sum   = a_val + b_val;
        diff  = a_val - b_val;
        prod  = a_val * b_val;
        mag_a = a_val[W-1] ? (W'(0) - a_val) : a_val;
        mag_b = b_val[W-1] ? (W'(0) - b_val) : b_val;
    end

    // One restoring divide step per cycle
    always_comb begin
        rem_sh    = {r_rem, r_quo[W-1]};
        rem_try   = rem_sh - {1'b0, r_divisor};
        quo_bit   = !rem_try[W];
        quo_fixed = r_neg ? (W'(0) - r_quo) : r_quo;
    end

    // Jump condition from the flags
    always_comb begin
        unique case (r_item.cond)
            COND_ALWAYS: taken = 1'b1;
            COND_EQ:     taken = r_zf;
            COND_NE:     taken = !r_zf;
            COND_GT:     taken = !r_cf && !r_zf;
            COND_LT:     taken = r_cf;
            COND_GE:     taken = r_zf || !r_cf;
            COND_LE:     taken = r_zf || r_cf;
            default:     taken = 1'b0;
        endcase
    end

    // Register file write and result for this cycle
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = r_item.left_reg[RF_AW-1:0];
        rf_wdata = '0;
        load_out = 1'b0;
        n_out    = '0;
        if (r_state == ST_EXEC) begin
            load_out = !((r_item.op == OP_DIV) && (b_val != '0));
            unique case (r_item.op)
                OP_MOV: begin
                    rf_we    = r_item.wr_left && r_left_in;
                    rf_wdata = b_val;
                end
                OP_ADD: begin
                    rf_we    = r_item.wr_left && r_left_in;
                    rf_wdata = sum;
                end
                OP_SUB: begin
                    rf_we    = r_item.wr_left && r_left_in;
                    rf_wdata = diff;
                end
                OP_MUL: begin
                    rf_we    = 1'b1;
                    rf_waddr = RESULT_REG;
                    rf_wdata = prod;
                end
                OP_DIV: begin
                    n_out.divide_error = (b_val == '0);
                end
                OP_JUMP: begin
                    n_out.branch_taken = taken;
                end
                OP_PRINT: begin
                    n_out.print_valid   = 1'b1;
                    n_out.print_is_char = r_item.is_char;
                    n_out.print_value   = r_item.is_char ? PRINT_W'(a_val[CHAR_W-1:0])
                                                         : PRINT_W'($signed(a_val));
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_FIX) begin
            rf_we    = 1'b1;
            rf_waddr = RESULT_REG;
            rf_wdata = quo_fixed;
            load_out = 1'b1;
        end
    end

    // Sequencer, flags, divider and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rf_vld    <= '0;
            r_zf        <= 1'b0;
            r_cf        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_item    <= i_q_item;
                        r_left_in <= q_left_in;
                        r_a_ok    <= q_left_in && r_rf_vld[RF_AW'(i_q_item.left_reg)];
                        r_b_ok    <= q_right_in && r_rf_vld[RF_AW'(i_q_item.right_reg)];
                        r_state   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (r_item.op == OP_CMP) begin
                        r_zf <= (diff == '0);
                        r_cf <= diff[W-1];
                    end
                    if ((r_item.op == OP_DIV) && (b_val != '0)) begin
                        r_rem     <= '0;
                        r_quo     <= mag_a;
                        r_divisor <= mag_b;
                        r_neg     <= a_val[W-1] ^ b_val[W-1];
                        r_cnt     <= DIV_CNT_W'(W - 1);
                        r_state   <= ST_DIV;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    r_rem <= quo_bit ? rem_try[W-1:0] : rem_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], quo_bit};
                    if (r_cnt == '0) begin
                        r_state <= ST_FIX;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_FIX: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // The result register is always free when an instruction executes
    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !r_out_valid)
        else $error("result register busy at execute");

    // The divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) || (r_state == ST_FIX)) |-> (r_divisor != '0))
        else $error("divider running with zero divisor");

    // Register file writes only happen while executing or finishing a divide
    a_rf_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> ((r_state == ST_EXEC) || (r_state == ST_FIX)))
        else $error("register file write outside execute");

    // A divide always leads to its final step after the iterations
    a_div_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_cnt == '0)) |=> (r_state == ST_FIX))
        else $error("divider did not finish");

endmodule

`default_nettype wire

// ===== hw/rtl/toy_register_machine_execute_unit.sv =====
// Execute unit of a small register machine: five 32-bit registers, zero and carry flags.
// Depends on trm_pkg, trm_front, trm_queue, trm_back (with trm_ram).
//
// Usage:
//   Input channel (i_valid / o_ready) carries one decoded instruction per transaction:
//   command, and for each operand a literal flag, a register index and a literal.
//   Output channel (o_valid / i_ready) returns exactly one result transaction per
//   instruction, in order: branch taken, print fields and divide error.
//   Each instruction passes the front stage, the queue, an operand read from the register
//   file RAM and execute; a divide with a nonzero divisor adds the one-bit-per-cycle divider.
//   The back end takes a new instruction only once the last has executed (operand read from
//   the register file RAM, then execute); a divide holds the back end until it finishes.
//   The front stage and a two-entry queue keep taking instructions while the back end
//   works or the receiver stalls; when the result register is held, the back end
//   waits and the queue fills, then o_ready drops.
//   Reset (synchronous, active low) clears the registers, flags, queue and result.
`timescale 1ns / 1ps
`default_nettype none

module toy_register_machine_execute_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [trm_pkg::CMD_W-1:0]             i_command,
    input  wire                                   i_left_is_literal,
    input  wire  [trm_pkg::REG_IDX_W-1:0]         i_left_reg,
    input  wire  [trm_pkg::LIT_W-1:0]             i_left_literal,
    input  wire                                   i_right_is_literal,
    input  wire  [trm_pkg::REG_IDX_W-1:0]         i_right_reg,
    input  wire  [trm_pkg::LIT_W-1:0]             i_right_literal,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic                                  o_branch_taken,
    output logic                                  o_print_valid,
    output logic                                  o_print_is_char,
    output logic signed [trm_pkg::PRINT_W-1:0]    o_print_value,
    output logic                                  o_divide_error
);
    import trm_pkg::*;

    logic    push;
    t_item   front_item;
    logic    queue_ready;
    logic    pop;
    logic    q_valid;
    t_item   q_item;
    t_result result;

    trm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_left_is_literal  (i_left_is_literal),
        .i_left_reg         (i_left_reg),
        .i_left_literal     (i_left_literal),
        .i_right_is_literal (i_right_is_literal),
        .i_right_reg        (i_right_reg),
        .i_right_literal    (i_right_literal),
        .o_push             (push),
        .o_item             (front_item),
        .i_queue_ready      (queue_ready)
    );

    trm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_in_ready  (queue_ready),
        .i_pop       (pop),
        .o_out_valid (q_valid),
        .o_item      (q_item)
    );

    trm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    // Unpack the result transaction
    assign o_branch_taken  = result.branch_taken;
    assign o_print_valid   = result.print_valid;
    assign o_print_is_char = result.print_is_char;
    assign o_print_value   = result.print_value;
    assign o_divide_error  = result.divide_error;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the register machine execute unit: one instruction in, one result out.
// Predicts every result in-bench and checks it against the unit's output channel.
// Depends on trm_pkg and toy_register_machine_execute_unit.
`timescale 1ns / 1ps

module tb_top;
    import trm_pkg::*;

    // One decoded instruction as it enters the unit
    typedef struct {
        t_cmd                 cmd;
        logic                 l_lit;
        logic [REG_IDX_W-1:0] l_reg;
        logic [LIT_W-1:0]     l_val;
        logic                 r_lit;
        logic [REG_IDX_W-1:0] r_reg;
        logic [LIT_W-1:0]     r_val;
    } t_instr;

    localparam int RANDOM_INSTRS = 525;
    localparam int HOLD_CYCLES   = 200;

    logic                        i_clk              = 1'b0;
    logic                        i_rst_n            = 1'b0;
    logic                        i_valid            = 1'b0;
    logic [CMD_W-1:0]            i_command          = '0;
    logic                        i_left_is_literal  = 1'b0;
    logic [REG_IDX_W-1:0]        i_left_reg         = '0;
    logic [LIT_W-1:0]            i_left_literal     = '0;
    logic                        i_right_is_literal = 1'b0;
    logic [REG_IDX_W-1:0]        i_right_reg        = '0;
    logic [LIT_W-1:0]            i_right_literal    = '0;
    logic                        i_ready            = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic                        o_branch_taken;
    logic                        o_print_valid;
    logic                        o_print_is_char;
    logic signed [PRINT_W-1:0]   o_print_value;
    logic                        o_divide_error;

    // Machine state as the bench sees it
    logic [DATA_WIDTH-1:0] mach_regs [NUM_REGISTERS] = '{default: '0};
    logic                  mach_zf = 1'b0;
    logic                  mach_cf = 1'b0;

    t_instr  instr_backlog[$];
    t_result predicted_results[$];

    int  instr_total    = 0;
    int  instr_accepted = 0;
    int  results_seen   = 0;
    int  err_count      = 0;
    int  n_divides      = 0;
    int  n_div_errors   = 0;
    int  n_prints       = 0;
    int  n_taken        = 0;
    int  n_input_stalls = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  xfer_in        = 1'b0;
    bit  hold_active    = 1'b0;

    toy_register_machine_execute_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_left_is_literal  (i_left_is_literal),
        .i_left_reg         (i_left_reg),
        .i_left_literal     (i_left_literal),
        .i_right_is_literal (i_right_is_literal),
        .i_right_reg        (i_right_reg),
        .i_right_literal    (i_right_literal),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_branch_taken     (o_branch_taken),
        .o_print_valid      (o_print_valid),
        .o_print_is_char    (o_print_is_char),
        .o_print_value      (o_print_value),
        .o_divide_error     (o_divide_error)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Read an operand; out-of-range register indexes read as zero
    function automatic logic [DATA_WIDTH-1:0] operand_val(input logic is_lit,
                                                          input logic [REG_IDX_W-1:0] idx,
                                                          input logic [LIT_W-1:0] lit);
        if (is_lit)
            return DATA_WIDTH'(lit);
        if (idx < NUM_REGISTERS)
            return mach_regs[idx];
        return '0;
    endfunction

    // Write a register; out-of-range indexes drop the write
    function automatic void write_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_WIDTH-1:0] value);
        if (idx < NUM_REGISTERS)
            mach_regs[idx] = value;
    endfunction

    // Execute one instruction on the bench state and return its result
    function automatic t_result execute_instr(input t_instr ins);
        t_result               res;
        logic [DATA_WIDTH-1:0] a, b, diff, mag_a, mag_b, quo;
        res = '0;
        a = operand_val(ins.l_lit, ins.l_reg, ins.l_val);
        b = operand_val(ins.r_lit, ins.r_reg, ins.r_val);
        case (ins.cmd)
            CMD_MOV: if (!ins.l_lit) write_reg(ins.l_reg, b);
            CMD_ADD: if (!ins.l_lit) write_reg(ins.l_reg, a + b);
            CMD_SUB: if (!ins.l_lit) write_reg(ins.l_reg, a - b);
            CMD_MUL: write_reg(REG_IDX_W'(RESULT_REG), a * b);
            CMD_DIV: begin
                if (b == '0) begin
                    res.divide_error = 1'b1;
                end else begin
                    // Divide magnitudes, then apply the sign: truncates toward zero
                    mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
                    mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
                    quo   = mag_a / mag_b;
                    if (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1])
                        quo = ~quo + 1'b1;
                    write_reg(REG_IDX_W'(RESULT_REG), quo);
                end
            end
            CMD_CMP: begin
                diff    = a - b;
                mach_zf = (diff == '0);
                mach_cf = diff[DATA_WIDTH-1];
            end
            CMD_JMP: res.branch_taken = 1'b1;
            CMD_JE:  res.branch_taken = mach_zf;
            CMD_JNE: res.branch_taken = !mach_zf;
            CMD_JG:  res.branch_taken = !mach_cf && !mach_zf;
            CMD_JL:  res.branch_taken = mach_cf;
            CMD_JGE: res.branch_taken = mach_zf || !mach_cf;
            CMD_JLE: res.branch_taken = mach_zf || mach_cf;
            CMD_PRINTINT: begin
                res.print_valid = 1'b1;
                res.print_value = PRINT_W'(signed'(a));
            end
            CMD_PRINTCHAR: begin
                res.print_valid   = 1'b1;
                res.print_is_char = 1'b1;
                res.print_value   = PRINT_W'(a[CHAR_W-1:0]);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_instr mk(input t_cmd c,
                                  input logic ll, input logic [REG_IDX_W-1:0] lr,
                                  input logic [LIT_W-1:0] lv,
                                  input logic rl, input logic [REG_IDX_W-1:0] rr,
                                  input logic [LIT_W-1:0] rv);
        t_instr it;
        it.cmd   = c;
        it.l_lit = ll;
        it.l_reg = lr;
        it.l_val = lv;
        it.r_lit = rl;
        it.r_reg = rr;
        it.r_val = rv;
        return it;
    endfunction

    // Literals lean toward the extremes and small values so compares can hit equal
    function automatic logic [LIT_W-1:0] rand_lit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {LIT_W{1'b1}};
            2:       return LIT_W'($urandom_range(0, 15));
            default: return LIT_W'($urandom);
        endcase
    endfunction

    // Mostly valid register indexes, sometimes out of range
    function automatic logic [REG_IDX_W-1:0] rand_reg();
        if ($urandom_range(0, 9) == 0)
            return REG_IDX_W'($urandom_range(NUM_REGISTERS, 7));
        return REG_IDX_W'($urandom_range(0, NUM_REGISTERS - 1));
    endfunction

    function automatic t_instr random_instr();
        t_instr it;
        it.cmd   = t_cmd'($urandom_range(0, 15));
        it.l_lit = ($urandom_range(0, 3) == 0);
        it.l_reg = rand_reg();
        it.l_val = rand_lit();
        it.r_lit = $urandom_range(0, 1);
        it.r_reg = rand_reg();
        it.r_val = rand_lit();
        return it;
    endfunction

    // Idle length: mostly none or short, a few long; some stretches run with no idling
    function automatic int pick_gap(input int progress);
        int roll;
        roll = $urandom_range(0, 99);
        if ((progress / 60) % 4 == 1)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            err_count++;
            $display("%0t: result %0d mismatch on %s, expected %0h, actual %0h",
                     $time, results_seen, fname, exp_v, act_v);
        end
    endtask

    // Driver: present the next instruction at the falling edge, hold it until accepted
    always @(negedge i_clk) begin
        t_instr nxt;
        if (i_rst_n && !(i_valid && !xfer_in)) begin
            xfer_in = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (instr_backlog.size() > 0) begin
                nxt = instr_backlog.pop_front();
                i_command          <= nxt.cmd;
                i_left_is_literal  <= nxt.l_lit;
                i_left_reg         <= nxt.l_reg;
                i_left_literal     <= nxt.l_val;
                i_right_is_literal <= nxt.r_lit;
                i_right_reg        <= nxt.r_reg;
                i_right_literal    <= nxt.r_val;
                i_valid            <= 1'b1;
                gap_left = pick_gap(instr_accepted);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_active) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            stall_left = pick_gap(results_seen);
        end
    end

    // Hold off the receiver for a long stretch so the unit fills and stalls its input
    initial begin : long_hold
        int n;
        while (instr_accepted < 150)
            @(posedge i_clk);
        hold_active = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge i_clk);
        hold_active = 1'b0;
    end

    // Monitor: predict on each accepted instruction, check each accepted result
    always @(posedge i_clk) begin
        t_instr  seen;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_ready)
                n_input_stalls++;
            if (i_valid && o_ready) begin
                seen.cmd   = t_cmd'(i_command);
                seen.l_lit = i_left_is_literal;
                seen.l_reg = i_left_reg;
                seen.l_val = i_left_literal;
                seen.r_lit = i_right_is_literal;
                seen.r_reg = i_right_reg;
                seen.r_val = i_right_literal;
                if (seen.cmd == CMD_DIV)
                    n_divides++;
                predicted_results.push_back(execute_instr(seen));
                instr_accepted++;
                xfer_in = 1'b1;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result %0d arrived with nothing expected", $time,
                             results_seen);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("branch_taken", 32'(want.branch_taken), 32'(o_branch_taken));
                    check_field("print_valid", 32'(want.print_valid), 32'(o_print_valid));
                    check_field("print_is_char", 32'(want.print_is_char),
                                32'(o_print_is_char));
                    check_field("print_value", want.print_value, o_print_value);
                    check_field("divide_error", 32'(want.divide_error), 32'(o_divide_error));
                    n_taken      += want.branch_taken;
                    n_prints     += want.print_valid;
                    n_div_errors += want.divide_error;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : main_seq
        int i;
        int guard;
        // Directed: word extremes, wrap, divide corners, literal and bad destinations, flags
        instr_backlog.push_back(mk(CMD_PRINTINT, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_MOV, 0, 0, 0, 1, 0, {LIT_W{1'b1}}));
        instr_backlog.push_back(mk(CMD_ADD, 0, 0, 0, 1, 0, 1));
        instr_backlog.push_back(mk(CMD_PRINTINT, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_SUB, 0, 1, 0, 1, 0, 1));
        // most negative over minus one wraps
        instr_backlog.push_back(mk(CMD_DIV, 0, 0, 0, 0, 1, 0));
        // zero divisor keeps the result register (index 4)
        instr_backlog.push_back(mk(CMD_DIV, 0, 0, 0, 1, 7, 0));
        instr_backlog.push_back(mk(CMD_PRINTINT, 0, 4, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_MUL, 0, 1, 0, 0, 1, 0));
        instr_backlog.push_back(mk(CMD_MOV, 1, 0, 3, 1, 0, 9));
        instr_backlog.push_back(mk(CMD_ADD, 1, 4, 5, 1, 0, 2));
        instr_backlog.push_back(mk(CMD_SUB, 1, 4, 5, 1, 0, 2));
        instr_backlog.push_back(mk(CMD_MOV, 0, 7, 0, 1, 0, 5));
        instr_backlog.push_back(mk(CMD_PRINTINT, 0, 6, {LIT_W{1'b1}}, 1, 5, 0));
        instr_backlog.push_back(mk(CMD_CMP, 0, 0, 0, 1, 0, 0));
        instr_backlog.push_back(mk(CMD_JL, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_JG, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_JLE, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_CMP, 0, 1, 0, 0, 1, 0));
        instr_backlog.push_back(mk(CMD_JE, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_JNE, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_JGE, 0, 0, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_JMP, 1, 7, {LIT_W{1'b1}}, 1, 7, {LIT_W{1'b1}}));
        instr_backlog.push_back(mk(CMD_PRINTCHAR, 0, 1, 0, 0, 0, 0));
        instr_backlog.push_back(mk(CMD_NOP, 1, 5, 31'h5555_5555, 0, 6, 31'h2AAA_AAAA));
        for (i = 0; i < RANDOM_INSTRS; i++)
            instr_backlog.push_back(random_instr());
        instr_total = instr_backlog.size();

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_accepted < instr_total)
            @(posedge i_clk);
        guard = 0;
        while (predicted_results.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        // Let any late or extra result show up
        repeat (DATA_WIDTH + 8) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     predicted_results.size());
        end

        $display("Ran %0d instructions (%0d divides, %0d by zero), checked %0d results.",
                 instr_accepted, n_divides, n_div_errors, results_seen);
        $display("Saw %0d prints, %0d taken jumps, %0d cycles of input backpressure.",
                 n_prints, n_taken, n_input_stalls);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
